// ===== rtl/sbus_fd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_fd_pkg
// Shared constants and types for the 25-byte receiver frame decoder.
// ----------------------------------------------------------------------------
package sbus_fd_pkg;

  localparam int FrameBytes = 25;

  localparam logic [7:0] StartByte = 8'h0F;
  localparam logic [7:0] EndByte   = 8'h00;

  localparam int ChanW      = 5;
  localparam int ValW       = 11;
  localparam int LostW      = 16;
  localparam int NumAnalog  = 16;
  localparam int NumResults = 18;

  localparam logic [ValW-1:0] DigitalOn = 11'h7FF;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_FRAME,
    ST_FLAGS,
    ST_FLAGW,
    ST_READ,
    ST_LOAD,
    ST_EMIT,
    ST_DIG
  } fd_state_e;

endpackage

// ===== rtl/sbus_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit
// Receiver frame decoder: 25-byte frames in, 18 channel words out.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one received byte per word. While hunting, bytes
// other than the start byte are dropped. After the start byte the next 24
// bytes go into a small frame memory, tready high, one byte per cycle while
// tvalid is high. If the final byte is the end byte the frame is decoded,
// else it is dropped and the block hunts again.
// Decoding: the flags byte is read first (digital channels, failsafe,
// lost-frame count), then a bit accumulator is filled from the memory one
// byte at a time, each through a read state and a load state, and emptied
// 11 bits at a time by a right shift; 16 analog words follow, then the two
// digital channel words, the last one with tlast set. The end byte starts
// the decode, with tready low until the last word is taken. Each byte needs
// a read state before its load state, as the memory read port is registered.
// Output stream (m_axis): each word is held in registers until taken; a
// stall simply holds the sequencer. Reset clears the sequencer and the lost
// count; the frame memory needs no reset.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit
  import sbus_fd_pkg::*;
#(
  parameter int FRAME_BYTES = FrameBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // channel_index, channel_value,
                                        // failsafe_active, lost_frame_total, pad
  output logic        m_axis_tlast_o    // last_of_frame
);

  localparam int StoreDepth = FRAME_BYTES - 1;
  localparam int FlagsIdx   = FRAME_BYTES - 3;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int AccW       = ValW + 7;
  localparam int CntW       = $clog2(AccW + 1);
  localparam int PadW       = 40 - (ChanW + ValW + 1 + LostW);

  fd_state_e state_q, state_d;

  logic [7:0]       mem_q [StoreDepth];
  logic [7:0]       rd_data_q;
  logic [AddrW-1:0] rd_addr;

  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ChanW-1:0] ch_q, ch_d;
  logic [1:0]       dig_q, dig_d;
  logic             fs_q, fs_d;
  logic [LostW-1:0] lost_q, lost_d;

  logic             in_fire;
  logic             out_fire;
  logic [ValW-1:0]  value;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_HUNT: begin
        if (in_fire && s_axis_tdata_i == StartByte) state_d = ST_FRAME;
      end
      ST_FRAME: begin
        if (in_fire && pos_q == AddrW'(StoreDepth - 1)) begin
          state_d = (s_axis_tdata_i == EndByte) ? ST_FLAGS : ST_HUNT;
        end
      end
      ST_FLAGS: state_d = ST_FLAGW;
      ST_FLAGW: state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD: begin
        state_d = ((CntW+1)'(cnt_q) + (CntW+1)'(8) >= (CntW+1)'(ValW)) ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (out_fire) state_d = (ch_q == ChanW'(NumAnalog - 1)) ? ST_DIG : ST_READ;
      end
      ST_DIG: begin
        if (out_fire && ch_q == ChanW'(NumResults - 1)) state_d = ST_HUNT;
      end
      default: state_d = ST_HUNT;
    endcase
  end

  // datapath
  always_comb begin
    pos_d    = pos_q;
    rd_ptr_d = rd_ptr_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    ch_d     = ch_q;
    dig_d    = dig_q;
    fs_d     = fs_q;
    lost_d   = lost_q;
    rd_addr  = rd_ptr_q;
    case (state_q)
      ST_HUNT: pos_d = '0;
      ST_FRAME: begin
        if (in_fire) pos_d = pos_q + AddrW'(1);
      end
      ST_FLAGS: rd_addr = AddrW'(FlagsIdx);
      ST_FLAGW: begin
        dig_d    = rd_data_q[1:0];
        fs_d     = rd_data_q[3];
        lost_d   = rd_data_q[2] ? lost_q + LostW'(1) : lost_q;
        acc_d    = '0;
        cnt_d    = '0;
        ch_d     = '0;
        rd_ptr_d = '0;
      end
      ST_READ: rd_ptr_d = rd_ptr_q + AddrW'(1);
      ST_LOAD: begin
        acc_d = acc_q | (AccW'(rd_data_q) << cnt_q);
        cnt_d = cnt_q + CntW'(8);
      end
      ST_EMIT: begin
        if (out_fire) begin
          acc_d = acc_q >> ValW;
          cnt_d = cnt_q - CntW'(ValW);
          ch_d  = ch_q + ChanW'(1);
        end
      end
      ST_DIG: begin
        if (out_fire) ch_d = ch_q + ChanW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FRAME && in_fire) mem_q[pos_q] <= s_axis_tdata_i;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    acc_q    <= acc_d;
    cnt_q    <= cnt_d;
    ch_q     <= ch_d;
    dig_q    <= dig_d;
    fs_q     <= fs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      pos_q   <= '0;
      lost_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      lost_q  <= lost_d;
    end
  end

  // outputs
  assign value = (state_q == ST_DIG) ? (dig_q[ch_q[0]] ? DigitalOn : '0) : acc_q[ValW-1:0];

  assign s_axis_tready_o = (state_q == ST_HUNT) || (state_q == ST_FRAME);
  assign m_axis_tvalid_o = (state_q == ST_EMIT) || (state_q == ST_DIG);
  assign m_axis_tdata_o  = {{PadW{1'b0}}, lost_q, fs_q, value, ch_q};
  assign m_axis_tlast_o  = (state_q == ST_DIG) && (ch_q == ChanW'(NumResults - 1));

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output active together");

  a_emit_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q >= CntW'(ValW))
    else $error("analog word emitted with too few bits");

  a_lost_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_FLAGW |=> $stable(lost_q))
    else $error("lost count changed outside flags load");

  a_dig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIG |-> (ch_q == ChanW'(NumAnalog) || ch_q == ChanW'(NumResults - 1)))
    else $error("digital channel index out of range");

endmodule
